### src/tgk_pkg.sv
// Shared types and constants for the touch gesture to key event block.
`default_nettype none
package tgk_pkg;

  localparam int EVENT_BITS = 3;
  localparam int TIME_BITS  = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Key event codes carried on the result channel.
  localparam logic [EVENT_BITS-1:0] EV_NONE  = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_DOWN  = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_UP    = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_RIGHT = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_LEFT  = 3'd4;
  localparam logic [EVENT_BITS-1:0] EV_BACK  = 3'd5;
  localparam logic [EVENT_BITS-1:0] EV_CLICK = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_PIXELS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_MIN     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS_MS = 2'd2;

  localparam logic [7:0]  STEP_PIXELS_RST   = 8'd20;
  localparam logic [7:0]  SWIPE_MIN_RST     = 8'd24;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd600;

  typedef enum logic [1:0] {
    AXIS_NONE  = 2'd0,
    AXIS_VERT  = 2'd1,
    AXIS_HORIZ = 2'd2
  } axis_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_DX,
    ST_DY,
    ST_DEC,
    ST_STEP_D,
    ST_STEP,
    ST_RD,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### src/tgk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tgk_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

### src/tgk_alu.sv
// Shared signed add/subtract unit used by the gesture sequencer.
`default_nettype none
module tgk_alu #(
  parameter int AW = 12
) (
  input  wire logic signed [AW-1:0] op_a,
  input  wire logic signed [AW-1:0] op_b,
  input  wire logic                 sub,
  output logic      signed [AW-1:0] res
);

  always_comb begin
    res = sub ? (op_a - op_b) : (op_a + op_b);
  end

endmodule
`default_nettype wire

### src/touch_gesture_to_key_events.sv
// Top level: touch samples in, one key event word out per sample.
// A sample with no math goes straight to the queue read; a tap, release or long-press check
// first forms the X and Y offsets, and a locked-axis sample then pushes up to QUEUE_SLOTS-1
// steps. One sample at a time; the next is taken once the word is in the output register, so
// the shared add/subtract unit (two uses per step) sets the rate. Reset (rst_n, synchronous,
// active low) clears the gesture state and queue pointers and restores register defaults.
`default_nettype none
module touch_gesture_to_key_events #(
  parameter int QUEUE_SLOTS = 8,
  parameter int COORD_BITS  = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tgk_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [tgk_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // Touch sample channel.
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_read_ok,
  input  wire logic                                in_finger_present,
  input  wire logic [COORD_BITS-1:0]               in_pos_x,
  input  wire logic [COORD_BITS-1:0]               in_pos_y,
  input  wire logic [tgk_pkg::TIME_BITS-1:0]       in_time_ms,
  // Key event channel.
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tgk_pkg::EVENT_BITS-1:0]           out_event_code
);
  import tgk_pkg::*;

  // Signed width that holds any coordinate difference.
  localparam int AW = COORD_BITS + 2;
  localparam int PW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

  // Configuration registers.
  logic [7:0]  step_pixels_r, step_pixels_nxt;
  logic [7:0]  swipe_min_r, swipe_min_nxt;
  logic [15:0] long_press_r, long_press_nxt;

  // Sequencer and latched sample.
  state_t state_r, state_nxt;
  logic                  ok_r, ok_nxt;
  logic                  fin_r, fin_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;

  // Gesture state.
  logic                  pressed_r, pressed_nxt;
  axis_t                 axis_r, axis_nxt;
  logic                  back_sent_r, back_sent_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0] last_x_r, last_x_nxt;
  logic [COORD_BITS-1:0] last_y_r, last_y_nxt;
  logic signed [AW-1:0]  anchor_x_r, anchor_x_nxt;
  logic signed [AW-1:0]  anchor_y_r, anchor_y_nxt;
  logic [TIME_BITS-1:0]  press_time_r, press_time_nxt;

  // Working values of the sequencer.
  logic signed [AW-1:0]  dx_r, dx_nxt;
  logic signed [AW-1:0]  dy_r, dy_nxt;
  logic signed [AW-1:0]  d_r, d_nxt;

  // Event queue pointers and output stage.
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic                  gap_r, gap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [EVENT_BITS-1:0] out_code_r, out_code_nxt;

  // Shared unit and queue memory hookup.
  logic signed [AW-1:0]  alu_a, alu_b, alu_res;
  logic                  alu_sub;
  logic                  push_en;
  logic [EVENT_BITS-1:0] push_code;
  logic [EVENT_BITS-1:0] ring_rd_data;

  // Helper values.
  logic [PW-1:0]         head_inc, tail_inc;
  logic                  q_full, q_empty;
  logic signed [AW-1:0]  step_s, neg_step_s, smin_s;
  logic signed [AW-1:0]  adx, ady;
  logic [TIME_BITS-1:0]  held_ms;
  logic                  lock_now;
  axis_t                 axis_eff;

  tgk_alu #(.AW(AW)) u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .res  (alu_res)
  );

  tgk_ram #(.WIDTH(EVENT_BITS), .DEPTH(QUEUE_SLOTS)) u_ring (
    .clk     (clk),
    .we      (push_en),
    .wr_addr (head_r),
    .wr_data (push_code),
    .rd_addr (tail_r),
    .rd_data (ring_rd_data)
  );

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  // Queue bookkeeping: the ring keeps one slot empty to tell full from empty.
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + PW'(1);
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + PW'(1);
  assign q_full   = (head_inc == tail_r);
  assign q_empty  = (head_r == tail_r);

  // A zero step size behaves as a step of one pixel.
  assign step_s     = (step_pixels_r == 8'd0) ? AW'(1) : AW'(step_pixels_r);
  assign neg_step_s = -step_s;
  assign smin_s     = AW'(swipe_min_r);
  assign adx        = dx_r[AW-1] ? -dx_r : dx_r;
  assign ady        = dy_r[AW-1] ? -dy_r : dy_r;
  // Timestamp difference wraps modulo 2^32 like the timestamp itself.
  assign held_ms    = now_r - press_time_r;
  assign lock_now   = (axis_r == AXIS_NONE) && ((adx >= smin_s) || (ady >= smin_s));
  assign axis_eff   = lock_now ? ((ady >= adx) ? AXIS_VERT : AXIS_HORIZ) : axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_pixels_r <= STEP_PIXELS_RST;
      swipe_min_r   <= SWIPE_MIN_RST;
      long_press_r  <= LONG_PRESS_MS_RST;
      pressed_r     <= 1'b0;
      axis_r        <= AXIS_NONE;
      back_sent_r   <= 1'b0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      anchor_x_r    <= '0;
      anchor_y_r    <= '0;
      press_time_r  <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      gap_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      step_pixels_r <= step_pixels_nxt;
      swipe_min_r   <= swipe_min_nxt;
      long_press_r  <= long_press_nxt;
      pressed_r     <= pressed_nxt;
      axis_r        <= axis_nxt;
      back_sent_r   <= back_sent_nxt;
      start_x_r     <= start_x_nxt;
      start_y_r     <= start_y_nxt;
      last_x_r      <= last_x_nxt;
      last_y_r      <= last_y_nxt;
      anchor_x_r    <= anchor_x_nxt;
      anchor_y_r    <= anchor_y_nxt;
      press_time_r  <= press_time_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      gap_r         <= gap_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    ok_r       <= ok_nxt;
    fin_r      <= fin_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    now_r      <= now_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    d_r        <= d_nxt;
    out_code_r <= out_code_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    step_pixels_nxt = step_pixels_r;
    swipe_min_nxt   = swipe_min_r;
    long_press_nxt  = long_press_r;
    ok_nxt          = ok_r;
    fin_nxt         = fin_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    now_nxt         = now_r;
    pressed_nxt     = pressed_r;
    axis_nxt        = axis_r;
    back_sent_nxt   = back_sent_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    last_x_nxt      = last_x_r;
    last_y_nxt      = last_y_r;
    anchor_x_nxt    = anchor_x_r;
    anchor_y_nxt    = anchor_y_r;
    press_time_nxt  = press_time_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    d_nxt           = d_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    gap_nxt         = gap_r;
    out_valid_nxt   = out_valid_r;
    out_code_nxt    = out_code_r;
    alu_a           = '0;
    alu_b           = '0;
    alu_sub         = 1'b1;
    push_en         = 1'b0;
    push_code       = EV_NONE;

    // The output register drains independently of the sequencer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Configuration writes must come only while the block is idle; the block does not check.
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_PIXELS:   step_pixels_nxt = cfg_wdata[7:0];
        CFG_SWIPE_MIN:     swipe_min_nxt   = cfg_wdata[7:0];
        CFG_LONG_PRESS_MS: long_press_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ok_nxt    = in_read_ok;
          fin_nxt   = in_finger_present;
          x_nxt     = in_pos_x;
          y_nxt     = in_pos_y;
          now_nxt   = in_time_ms;
          state_nxt = ST_PRE;
        end
      end

      // Classify the sample: new press, held finger, release, or nothing.
      ST_PRE: begin
        state_nxt = ST_RD;
        if (ok_r && fin_r && !pressed_r) begin
          pressed_nxt    = 1'b1;
          axis_nxt       = AXIS_NONE;
          back_sent_nxt  = 1'b0;
          start_x_nxt    = x_r;
          start_y_nxt    = y_r;
          last_x_nxt     = x_r;
          last_y_nxt     = y_r;
          anchor_x_nxt   = AW'(x_r);
          anchor_y_nxt   = AW'(y_r);
          press_time_nxt = now_r;
        end else if (ok_r && fin_r) begin
          last_x_nxt = x_r;
          last_y_nxt = y_r;
          state_nxt  = ST_DX;
        end else if (ok_r && pressed_r) begin
          // A release that reports the origin keeps the last held position.
          if ((x_r != '0) || (y_r != '0)) begin
            last_x_nxt = x_r;
            last_y_nxt = y_r;
          end
          pressed_nxt = 1'b0;
          state_nxt   = ST_DX;
        end
      end

      ST_DX: begin
        alu_a     = AW'(last_x_r);
        alu_b     = AW'(start_x_r);
        dx_nxt    = alu_res;
        state_nxt = ST_DY;
      end

      ST_DY: begin
        alu_a     = AW'(last_y_r);
        alu_b     = AW'(start_y_r);
        dy_nxt    = alu_res;
        state_nxt = ST_DEC;
      end

      // Decide what the held or released gesture produces.
      ST_DEC: begin
        state_nxt = ST_RD;
        if (fin_r) begin
          if (lock_now) begin
            axis_nxt     = axis_eff;
            anchor_x_nxt = AW'(start_x_r);
            anchor_y_nxt = AW'(start_y_r);
          end
          if (axis_eff != AXIS_NONE) begin
            state_nxt = ST_STEP_D;
          end else if (!back_sent_r && (held_ms >= TIME_BITS'(long_press_r))) begin
            back_sent_nxt = 1'b1;
            push_en       = !q_full;
            push_code     = EV_BACK;
          end
        end else if (!back_sent_r && (axis_r == AXIS_NONE)) begin
          // Release of an unlocked gesture: a tap or a quick flick.
          push_en = !q_full;
          if ((adx < smin_s) && (ady < smin_s)) begin
            push_code = EV_CLICK;
          end else if (ady >= adx) begin
            push_code = (!dy_r[AW-1] && (dy_r != '0)) ? EV_DOWN : EV_UP;
          end else begin
            push_code = (!dx_r[AW-1] && (dx_r != '0)) ? EV_RIGHT : EV_LEFT;
          end
        end
      end

      // Distance from the anchor along the locked axis.
      ST_STEP_D: begin
        if (axis_r == AXIS_VERT) begin
          alu_a = AW'(last_y_r);
          alu_b = anchor_y_r;
        end else begin
          alu_a = AW'(last_x_r);
          alu_b = anchor_x_r;
        end
        d_nxt     = alu_res;
        state_nxt = ST_STEP;
      end

      // One whole step per pass; a full queue leaves the anchor where it is.
      ST_STEP: begin
        alu_a = (axis_r == AXIS_VERT) ? anchor_y_r : anchor_x_r;
        alu_b = step_s;
        if (((d_r >= step_s) || (d_r <= neg_step_s)) && !q_full) begin
          alu_sub = (d_r <= neg_step_s);
          push_en = 1'b1;
          if (axis_r == AXIS_VERT) begin
            push_code    = (d_r >= step_s) ? EV_DOWN : EV_UP;
            anchor_y_nxt = alu_res;
          end else begin
            push_code    = (d_r >= step_s) ? EV_RIGHT : EV_LEFT;
            anchor_x_nxt = alu_res;
          end
          state_nxt = ST_STEP_D;
        end else begin
          state_nxt = ST_RD;
        end
      end

      // Lets the registered read of the queue memory present the entry at the tail.
      ST_RD: begin
        state_nxt = ST_OUT;
      end

      // Each sample returns one word: a forced none after a real event,
      // otherwise the oldest queued event or none.
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (gap_r) begin
            gap_nxt      = 1'b0;
            out_code_nxt = EV_NONE;
          end else if (q_empty) begin
            out_code_nxt = EV_NONE;
          end else begin
            out_code_nxt = ring_rd_data;
            tail_nxt     = tail_inc;
            gap_nxt      = (ring_rd_data != EV_NONE);
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (push_en) begin
      head_nxt = head_inc;
    end
  end

endmodule
`default_nettype wire
